@@ src/qrs_pkg.sv @@
// shared constants and types for the quadratic root solver
package qrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_WIDTH = 34;

	typedef enum logic [2:0] {
		KIND_LINEAR   = 3'd0,
		KIND_INVALID  = 3'd1,
		KIND_TWO_REAL = 3'd2,
		KIND_DOUBLE   = 3'd3,
		KIND_COMPLEX  = 3'd4
	} root_kind_t;

endpackage

@@ src/quadratic_root_solver_top.sv @@
// top level of the quadratic root solver: pipeline, root combine, saturation, output skid
// Solves a*x^2 + b*x + c = 0 for signed coef_a, coef_b, coef_c and returns root_kind with two
// signed Q(34-FRAC_BITS).FRAC_BITS values, all divisions truncating toward zero. The block is a
// fully pipelined datapath that takes one transaction per clock while in_stall is low; its
// depth is set by the square root pipeline (one bit per stage) followed by the restoring
// divider (one quotient bit per stage). A two-entry output buffer lets results wait under
// out_stall without bubbles; in_stall is registered and rises only when that buffer is full.
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic out_valid,
	input  logic out_stall,
	output qrs_pkg::root_kind_t root_kind,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value
);
	import qrs_pkg::*;

	localparam int NW = COEF_WIDTH + FRAC_BITS + 3;
	localparam int DENW = COEF_WIDTH + 2;
	localparam int DW = 2 * COEF_WIDTH + 2;
	localparam int RTW = COEF_WIDTH + FRAC_BITS + 1;
	localparam int SBW = 3 + NW + DENW;
	localparam int EW = (NW > OUT_WIDTH) ? NW : OUT_WIDTH;
	localparam logic signed [EW-1:0] SAT_HI =
		{{(EW - OUT_WIDTH + 1){1'b0}}, {(OUT_WIDTH - 1){1'b1}}};
	localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

	logic en;
	logic skid_v_q;

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	// front end
	logic fr_valid;
	root_kind_t fr_kind;
	logic [DW-1:0] fr_mag;
	logic signed [NW-1:0] fr_numer;
	logic signed [DENW-1:0] fr_den;

	qrs_front #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.coef_a(coef_a),
		.coef_b(coef_b),
		.coef_c(coef_c),
		.out_valid(fr_valid),
		.kind(fr_kind),
		.disc_mag(fr_mag),
		.numer(fr_numer),
		.den(fr_den)
	);

	// square root, with kind, numerator base and divisor riding alongside
	logic sq_valid;
	logic [RTW-1:0] sq_root;
	logic [SBW-1:0] sq_sb;

	qrs_sqrt #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.SB_WIDTH(SBW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fr_valid),
		.radicand(fr_mag),
		.sb_in({fr_kind, fr_numer, fr_den}),
		.out_valid(sq_valid),
		.root(sq_root),
		.sb_out(sq_sb)
	);

	root_kind_t sq_kind;
	logic signed [NW-1:0] sq_numer, s_ext;
	logic signed [DENW-1:0] sq_den;
	logic signed [NW-1:0] n1_c, n2_c;

	assign sq_kind = root_kind_t'(sq_sb[SBW-1 -: 3]);
	assign sq_numer = sq_sb[NW+DENW-1:DENW];
	assign sq_den = sq_sb[DENW-1:0];
	assign s_ext = signed'(NW'(sq_root));

	always_comb begin
		case (sq_kind)
			KIND_TWO_REAL: begin
				n1_c = sq_numer + s_ext;
				n2_c = sq_numer - s_ext;
			end
			KIND_COMPLEX: begin
				n1_c = sq_numer;
				n2_c = s_ext;
			end
			KIND_LINEAR, KIND_DOUBLE: begin
				n1_c = sq_numer;
				n2_c = '0;
			end
			default: begin
				n1_c = '0;
				n2_c = '0;
			end
		endcase
	end

	logic cmb_v_s;
	root_kind_t cmb_kind_s;
	logic signed [NW-1:0] cmb_n1_s, cmb_n2_s;
	logic signed [DENW-1:0] cmb_den_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmb_v_s <= 1'b0;
		end else if (en) begin
			cmb_v_s <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmb_kind_s <= sq_kind;
			cmb_n1_s <= n1_c;
			cmb_n2_s <= n2_c;
			cmb_den_s <= sq_den;
		end
	end

	// division by 2a, or by b for the linear case
	logic dv_valid;
	logic signed [NW-1:0] dv_q1, dv_q2;
	root_kind_t dv_kind;

	qrs_div #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(cmb_v_s),
		.num1(cmb_n1_s),
		.num2(cmb_n2_s),
		.den(cmb_den_s),
		.kind_in(cmb_kind_s),
		.out_valid(dv_valid),
		.quo1(dv_q1),
		.quo2(dv_q2),
		.kind_out(dv_kind)
	);

	// saturate to the output width
	logic signed [EW-1:0] q1_ext, q2_ext, q1_sat, q2_sat;

	assign q1_ext = EW'(dv_q1);
	assign q2_ext = EW'(dv_q2);
	assign q1_sat = (q1_ext > SAT_HI) ? SAT_HI : ((q1_ext < SAT_LO) ? SAT_LO : q1_ext);
	assign q2_sat = (q2_ext > SAT_HI) ? SAT_HI : ((q2_ext < SAT_LO) ? SAT_LO : q2_ext);

	logic sat_v_s;
	root_kind_t sat_kind_s;
	logic signed [OUT_WIDTH-1:0] sat_f_s, sat_s_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_v_s <= 1'b0;
		end else if (en) begin
			sat_v_s <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_kind_s <= dv_kind;
			sat_f_s <= q1_sat[OUT_WIDTH-1:0];
			sat_s_s <= q2_sat[OUT_WIDTH-1:0];
		end
	end

	// output register plus skid entry
	logic incoming;
	logic out_v_q;
	root_kind_t out_kind_q, skid_kind_q;
	logic signed [OUT_WIDTH-1:0] out_f_q, out_s_q, skid_f_q, skid_s_q;

	assign incoming = en && sat_v_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= incoming;
			end
		end else if (incoming) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_kind_q <= skid_kind_q;
				out_f_q <= skid_f_q;
				out_s_q <= skid_s_q;
			end else begin
				out_kind_q <= sat_kind_s;
				out_f_q <= sat_f_s;
				out_s_q <= sat_s_s;
			end
		end else if (incoming) begin
			skid_kind_q <= sat_kind_s;
			skid_f_q <= sat_f_s;
			skid_s_q <= sat_s_s;
		end
	end

	assign out_valid = out_v_q;
	assign root_kind = out_kind_q;
	assign first_value = out_f_q;
	assign second_value = out_s_q;

endmodule

@@ src/qrs_front.sv @@
// front stages: products, discriminant, case decode, numerator base and divisor
module qrs_front #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [COEF_WIDTH-1:0] coef_a,
	input  logic signed [COEF_WIDTH-1:0] coef_b,
	input  logic signed [COEF_WIDTH-1:0] coef_c,
	output logic out_valid,
	output qrs_pkg::root_kind_t kind,
	output logic [2*COEF_WIDTH+1:0] disc_mag,
	output logic signed [COEF_WIDTH+FRAC_BITS+2:0] numer,
	output logic signed [COEF_WIDTH+1:0] den
);
	import qrs_pkg::*;

	localparam int NW = COEF_WIDTH + FRAC_BITS + 3;
	localparam int DENW = COEF_WIDTH + 2;
	localparam int DSW = 2 * COEF_WIDTH + 3;
	localparam int DW = 2 * COEF_WIDTH + 2;

	logic v_s1;
	logic signed [COEF_WIDTH-1:0] a_s1, b_s1, c_s1;
	logic signed [2*COEF_WIDTH-1:0] bb_s1, ac_s1;

	logic signed [DSW-1:0] disc;
	logic signed [DSW-1:0] disc_neg;
	logic signed [NW-1:0] b_ext, c_ext;
	logic a_zero, b_zero;
	root_kind_t kind_c;
	logic signed [NW-1:0] numer_c;
	logic signed [DENW-1:0] den_c;

	logic v_s2;
	root_kind_t kind_s2;
	logic [DW-1:0] mag_s2;
	logic signed [NW-1:0] numer_s2;
	logic signed [DENW-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= coef_a;
			b_s1 <= coef_b;
			c_s1 <= coef_c;
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
		end
	end

	always_comb begin
		disc = DSW'(bb_s1) - (DSW'(ac_s1) <<< 2);
		disc_neg = -disc;
		b_ext = NW'(b_s1);
		c_ext = NW'(c_s1);
		a_zero = (a_s1 == '0);
		b_zero = (b_s1 == '0);
		if (a_zero) begin
			numer_c = -(c_ext <<< FRAC_BITS);
			if (b_zero) begin
				kind_c = KIND_INVALID;
				den_c = DENW'(1);
			end else begin
				kind_c = KIND_LINEAR;
				den_c = DENW'(b_s1);
			end
		end else begin
			numer_c = -(b_ext <<< FRAC_BITS);
			den_c = DENW'(a_s1) <<< 1;
			if (disc > 0) begin
				kind_c = KIND_TWO_REAL;
			end else if (disc == '0) begin
				kind_c = KIND_DOUBLE;
			end else begin
				kind_c = KIND_COMPLEX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_c;
			mag_s2 <= disc[DSW-1] ? disc_neg[DW-1:0] : disc[DW-1:0];
			numer_s2 <= numer_c;
			den_s2 <= den_c;
		end
	end

	assign out_valid = v_s2;
	assign kind = kind_s2;
	assign disc_mag = mag_s2;
	assign numer = numer_s2;
	assign den = den_s2;

endmodule

@@ src/qrs_sqrt.sv @@
// pipelined digit-recurrence square root, one result bit per stage
module qrs_sqrt #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
	parameter int SB_WIDTH = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [2*COEF_WIDTH+1:0] radicand,
	input  logic [SB_WIDTH-1:0] sb_in,
	output logic out_valid,
	output logic [COEF_WIDTH+FRAC_BITS:0] root,
	output logic [SB_WIDTH-1:0] sb_out
);
	localparam int N = COEF_WIDTH + FRAC_BITS + 1;
	localparam int DW = 2 * COEF_WIDTH + 2;
	localparam int RW = N + 2;

	logic [N-1:0] v_s;
	logic [N-1:0] root_s [N];
	logic [RW-1:0] rem_s [N];
	logic [DW-1:0] d_s [N];
	logic [SB_WIDTH-1:0] sb_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int I = COEF_WIDTH - k;
		logic v_prev;
		logic [N-1:0] root_prev;
		logic [RW-1:0] rem_prev;
		logic [DW-1:0] d_prev;
		logic [SB_WIDTH-1:0] sb_prev;
		logic [1:0] pair;
		logic [RW-1:0] remsh, trial, diff;
		logic ge;

		if (k == 0) begin : g_first
			assign v_prev = in_valid;
			assign root_prev = '0;
			assign rem_prev = '0;
			assign d_prev = radicand;
			assign sb_prev = sb_in;
		end else begin : g_rest
			assign v_prev = v_s[k-1];
			assign root_prev = root_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign d_prev = d_s[k-1];
			assign sb_prev = sb_s[k-1];
		end

		if (I >= 0) begin : g_pair
			assign pair = d_prev[2*I+1:2*I];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign remsh = {rem_prev[RW-3:0], pair};
		assign trial = {root_prev, 2'b01};
		assign ge = (remsh >= trial);
		assign diff = remsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_prev[N-2:0], ge};
				rem_s[k] <= ge ? diff : remsh;
				d_s[k] <= d_prev;
				sb_s[k] <= sb_prev;
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign root = root_s[N-1];
	assign sb_out = sb_s[N-1];

endmodule

@@ src/qrs_div.sv @@
// pipelined signed restoring divider, two numerators over one shared divisor
module qrs_div #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [COEF_WIDTH+FRAC_BITS+2:0] num1,
	input  logic signed [COEF_WIDTH+FRAC_BITS+2:0] num2,
	input  logic signed [COEF_WIDTH+1:0] den,
	input  qrs_pkg::root_kind_t kind_in,
	output logic out_valid,
	output logic signed [COEF_WIDTH+FRAC_BITS+2:0] quo1,
	output logic signed [COEF_WIDTH+FRAC_BITS+2:0] quo2,
	output qrs_pkg::root_kind_t kind_out
);
	import qrs_pkg::*;

	localparam int NW = COEF_WIDTH + FRAC_BITS + 3;
	localparam int MW = NW - 1;
	localparam int DENW = COEF_WIDTH + 2;
	localparam int DM = DENW - 1;

	logic signed [NW-1:0] num1_neg, num2_neg;
	logic signed [DENW-1:0] den_neg;
	logic [MW-1:0] n1_in, n2_in;
	logic [DM-1:0] d_in;
	logic sg1_in, sg2_in;

	assign num1_neg = -num1;
	assign num2_neg = -num2;
	assign den_neg = -den;
	assign n1_in = num1[NW-1] ? num1_neg[MW-1:0] : num1[MW-1:0];
	assign n2_in = num2[NW-1] ? num2_neg[MW-1:0] : num2[MW-1:0];
	assign d_in = den[DENW-1] ? den_neg[DM-1:0] : den[DM-1:0];
	assign sg1_in = num1[NW-1] ^ den[DENW-1];
	assign sg2_in = num2[NW-1] ^ den[DENW-1];

	logic [MW-1:0] v_s;
	logic [MW-1:0] n1_s [MW];
	logic [MW-1:0] n2_s [MW];
	logic [MW-1:0] q1_s [MW];
	logic [MW-1:0] q2_s [MW];
	logic [DM-1:0] r1_s [MW];
	logic [DM-1:0] r2_s [MW];
	logic [DM-1:0] d_s [MW];
	logic sg1_s [MW];
	logic sg2_s [MW];
	root_kind_t kind_s [MW];

	for (genvar k = 0; k < MW; k++) begin : g_stage
		logic v_prev, sg1_prev, sg2_prev;
		logic [MW-1:0] n1_prev, n2_prev, q1_prev, q2_prev;
		logic [DM-1:0] r1_prev, r2_prev, d_prev;
		root_kind_t kind_prev;
		logic [DM:0] rsh1, rsh2, diff1, diff2;
		logic ge1, ge2;

		if (k == 0) begin : g_first
			assign v_prev = in_valid;
			assign n1_prev = n1_in;
			assign n2_prev = n2_in;
			assign q1_prev = '0;
			assign q2_prev = '0;
			assign r1_prev = '0;
			assign r2_prev = '0;
			assign d_prev = d_in;
			assign sg1_prev = sg1_in;
			assign sg2_prev = sg2_in;
			assign kind_prev = kind_in;
		end else begin : g_rest
			assign v_prev = v_s[k-1];
			assign n1_prev = n1_s[k-1];
			assign n2_prev = n2_s[k-1];
			assign q1_prev = q1_s[k-1];
			assign q2_prev = q2_s[k-1];
			assign r1_prev = r1_s[k-1];
			assign r2_prev = r2_s[k-1];
			assign d_prev = d_s[k-1];
			assign sg1_prev = sg1_s[k-1];
			assign sg2_prev = sg2_s[k-1];
			assign kind_prev = kind_s[k-1];
		end

		assign rsh1 = {r1_prev, n1_prev[MW-1]};
		assign rsh2 = {r2_prev, n2_prev[MW-1]};
		assign ge1 = (rsh1 >= {1'b0, d_prev});
		assign ge2 = (rsh2 >= {1'b0, d_prev});
		assign diff1 = rsh1 - {1'b0, d_prev};
		assign diff2 = rsh2 - {1'b0, d_prev};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n1_s[k] <= n1_prev << 1;
				n2_s[k] <= n2_prev << 1;
				q1_s[k] <= {q1_prev[MW-2:0], ge1};
				q2_s[k] <= {q2_prev[MW-2:0], ge2};
				r1_s[k] <= ge1 ? diff1[DM-1:0] : rsh1[DM-1:0];
				r2_s[k] <= ge2 ? diff2[DM-1:0] : rsh2[DM-1:0];
				d_s[k] <= d_prev;
				sg1_s[k] <= sg1_prev;
				sg2_s[k] <= sg2_prev;
				kind_s[k] <= kind_prev;
			end
		end
	end

	logic signed [NW-1:0] mag1, mag2;

	assign mag1 = signed'(NW'(q1_s[MW-1]));
	assign mag2 = signed'(NW'(q2_s[MW-1]));
	assign out_valid = v_s[MW-1];
	assign quo1 = sg1_s[MW-1] ? -mag1 : mag1;
	assign quo2 = sg2_s[MW-1] ? -mag2 : mag2;
	assign kind_out = kind_s[MW-1];

endmodule
